### rtl/tpp_pkg.sv
// Shared definitions for the turtle pen plotter: grid size, command codes,
// field widths and the canvas access bundle.
// No dependencies.
package tpp_pkg;

    localparam int GRID_SIZE = 64;
    localparam int COORD_W   = 6;
    localparam int ROW_W     = 64;
    localparam int STEPS_W   = 8;
    localparam int CMD_W     = 3;
    localparam int HEAD_W    = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PEN_UP   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PEN_DOWN = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOVE     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DUMP     = 3'd5;

    // Heading codes
    localparam logic [HEAD_W-1:0] HEAD_NORTH = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_EAST  = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_SOUTH = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_WEST  = 2'd3;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_CMD = 1'b1;

    // Canvas access from the sequencer
    typedef struct packed {
        logic               rd_en;
        logic [COORD_W-1:0] rd_addr;
        logic               wr_en;
        logic [COORD_W-1:0] wr_addr;
        logic [ROW_W-1:0]   wr_data;
    } cv_req_t;

endpackage

### rtl/tpp_stepper.sv
// Unit step of the cursor: one position update with clamping at the grid edge.
// Depends on tpp_pkg.
module tpp_stepper
    import tpp_pkg::*;
(
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [HEAD_W-1:0]  heading,
    output logic [COORD_W-1:0] step_x,
    output logic [COORD_W-1:0] step_y
);

    localparam logic [COORD_W-1:0] EDGE = COORD_W'(GRID_SIZE - 1);

    // Advance one cell along the heading, hold at the edge
    always_comb
    begin
        step_x = pos_x;
        step_y = pos_y;
        case (heading)
            HEAD_NORTH:
            begin
                if (pos_y != '0)
                    step_y = pos_y - COORD_W'(1);
            end
            HEAD_EAST:
            begin
                if (pos_x < EDGE)
                    step_x = pos_x + COORD_W'(1);
            end
            HEAD_SOUTH:
            begin
                if (pos_y < EDGE)
                    step_y = pos_y + COORD_W'(1);
            end
            default:
            begin
                if (pos_x != '0)
                    step_x = pos_x - COORD_W'(1);
            end
        endcase
    end

endmodule

### rtl/tpp_canvas.sv
// Bitmap store: one row per entry, single write and single registered read port.
// Per-row valid flags make unwritten rows read as cleared. Depends on tpp_pkg.
module tpp_canvas
    import tpp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cv_req_t          req,
    output logic [ROW_W-1:0] rd_data
);

    localparam int ROW_AW = $clog2(GRID_SIZE);

    logic [ROW_W-1:0]     mem [GRID_SIZE];
    logic [ROW_W-1:0]     rd_word_reg;
    logic                 rd_hit_reg;
    logic [GRID_SIZE-1:0] rows_valid_reg;

    // Write and read the row array
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr[ROW_AW-1:0]] <= req.wr_data;
        if (req.rd_en)
            rd_word_reg <= mem[req.rd_addr[ROW_AW-1:0]];
    end

    // Track which rows have been written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_valid_reg <= '0;
            rd_hit_reg     <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
                rows_valid_reg[req.wr_addr[ROW_AW-1:0]] <= 1'b1;
            if (req.rd_en)
                rd_hit_reg <= rows_valid_reg[req.rd_addr[ROW_AW-1:0]];
        end
    end

    // Drop stale contents of never-written rows
    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

### rtl/turtle_pen_plotter_core.sv
// Turtle plotter top level: command sequencer, cursor state and result register.
// Depends on tpp_pkg, tpp_stepper and tpp_canvas.
//
// One command is taken at a time; req_stall stays high until the command has
// finished and its results have been queued. Pen up, turns, zero-length moves
// and unknown commands load their reply without touching the canvas; pen down
// marks the cursor cell, a move marks each cell it enters while the pen is
// down, and a dump reads out all 64 rows, waiting while rsp_stall holds a row
// back. The canvas memory has a registered read port: marking a cell is a read
// then a write of its row, and each dumped row is one read before it can be
// loaded into the result register. The canvas needs no clearing pass after
// reset: per-row flags cleared by reset make unwritten rows read as zero.
module turtle_pen_plotter_core
    import tpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [STEPS_W-1:0] steps,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [ROW_W-1:0]   row_bits,
    output logic [COORD_W-1:0] row_index,
    output logic               last,
    output logic               status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_MARK,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

    localparam logic [COORD_W-1:0] LAST_ROW = COORD_W'(GRID_SIZE - 1);

    state_t             state_reg, state_next;
    logic [COORD_W-1:0] pos_x_reg, pos_x_next;
    logic [COORD_W-1:0] pos_y_reg, pos_y_next;
    logic [HEAD_W-1:0]  heading_reg, heading_next;
    logic               pen_reg, pen_next;
    logic [STEPS_W-1:0] cnt_reg, cnt_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic               out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]   out_bits_reg, out_bits_next;
    logic [COORD_W-1:0] out_index_reg, out_index_next;
    logic               out_last_reg, out_last_next;
    logic               out_status_reg, out_status_next;

    logic               accept;
    logic               out_free;
    logic [COORD_W-1:0] step_x, step_y;
    logic [ROW_W-1:0]   rd_data;
    cv_req_t            cv_req;

    tpp_stepper u_stepper (
        .pos_x   (pos_x_reg),
        .pos_y   (pos_y_reg),
        .heading (heading_reg),
        .step_x  (step_x),
        .step_y  (step_y)
    );

    tpp_canvas u_canvas (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (cv_req),
        .rd_data (rd_data)
    );

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE) || !out_free;
    assign accept    = req_valid && !req_stall;

    // Sequence commands, drive the canvas and load results
    always_comb
    begin
        state_next      = state_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        heading_next    = heading_reg;
        pen_next        = pen_reg;
        cnt_next        = cnt_reg;
        row_next        = row_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_bits_next   = out_bits_reg;
        out_index_next  = out_index_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;

        cv_req.rd_en    = 1'b0;
        cv_req.rd_addr  = pos_y_reg;
        cv_req.wr_en    = 1'b0;
        cv_req.wr_addr  = pos_y_reg;
        cv_req.wr_data  = rd_data | (ROW_W'(1) << pos_x_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Single-result reply by default
                    out_bits_next   = '0;
                    out_index_next  = '0;
                    out_last_next   = 1'b1;
                    out_status_next = STATUS_OK;
                    case (cmd)
                        CMD_PEN_UP:
                        begin
                            pen_next       = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        CMD_PEN_DOWN:
                        begin
                            pen_next     = 1'b1;
                            cnt_next     = STEPS_W'(1);
                            cv_req.rd_en = 1'b1;
                            state_next   = S_MARK;
                        end
                        CMD_RIGHT:
                        begin
                            heading_next   = heading_reg + HEAD_W'(1);
                            out_valid_next = 1'b1;
                        end
                        CMD_LEFT:
                        begin
                            heading_next   = heading_reg + HEAD_W'(3);
                            out_valid_next = 1'b1;
                        end
                        CMD_MOVE:
                        begin
                            if (steps == '0)
                                out_valid_next = 1'b1;
                            else
                            begin
                                cnt_next   = steps;
                                state_next = S_STEP;
                            end
                        end
                        CMD_DUMP:
                        begin
                            row_next   = '0;
                            state_next = S_DUMP_RD;
                        end
                        default:
                        begin
                            out_status_next = STATUS_BAD_CMD;
                            out_valid_next  = 1'b1;
                        end
                    endcase
                end
            end
            S_STEP:
            begin
                // Advance one cell; fetch its row when the pen is down
                pos_x_next = step_x;
                pos_y_next = step_y;
                if (pen_reg)
                begin
                    cv_req.rd_en   = 1'b1;
                    cv_req.rd_addr = step_y;
                    state_next     = S_MARK;
                end
                else if (cnt_reg == STEPS_W'(1))
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                    cnt_next = cnt_reg - STEPS_W'(1);
            end
            S_MARK:
            begin
                // Write back the row with the current cell set
                cv_req.wr_en = 1'b1;
                if (cnt_reg == STEPS_W'(1))
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg - STEPS_W'(1);
                    state_next = S_STEP;
                end
            end
            S_DUMP_RD:
            begin
                cv_req.rd_en   = 1'b1;
                cv_req.rd_addr = row_reg;
                state_next     = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                // Hand the row on once the result register is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_bits_next   = rd_data;
                    out_index_next  = row_reg;
                    out_last_next   = (row_reg == LAST_ROW);
                    out_status_next = STATUS_OK;
                    if (row_reg == LAST_ROW)
                        state_next = S_IDLE;
                    else
                    begin
                        row_next   = row_reg + COORD_W'(1);
                        state_next = S_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state, cursor and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            heading_reg    <= HEAD_EAST;
            pen_reg        <= 1'b0;
            cnt_reg        <= '0;
            row_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_bits_reg   <= '0;
            out_index_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            heading_reg    <= heading_next;
            pen_reg        <= pen_next;
            cnt_reg        <= cnt_next;
            row_reg        <= row_next;
            out_valid_reg  <= out_valid_next;
            out_bits_reg   <= out_bits_next;
            out_index_reg  <= out_index_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign row_bits  = out_bits_reg;
    assign row_index = out_index_reg;
    assign last      = out_last_reg;
    assign status    = out_status_reg;

    // A new command never arrives while a result is still held back
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(rsp_valid && rsp_stall))
        else $error("command accepted while a result is pending");

    // Pen up replies in the very next cycle with a final result
    a_pen_up_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_PEN_UP) |=> (rsp_valid && last && status == STATUS_OK))
        else $error("pen up did not reply in one cycle");

    // Step and mark phases always have work left
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP || state_reg == S_MARK) |-> (cnt_reg != '0))
        else $error("step counter empty during a move");

    // Cursor stays on the grid
    a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_x_reg <= LAST_ROW) && (pos_y_reg <= LAST_ROW))
        else $error("cursor left the grid");

endmodule

### tb/sv/turtle_pen_plotter_core_tb.sv
// Self-checking testbench for turtle_pen_plotter_core: directed and random command
// streams with random idling on both sides, checked against a cycle-free plotter model.
// Depends on tpp_pkg and the turtle_pen_plotter_core RTL.
module turtle_pen_plotter_core_tb;

    import tpp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

    localparam int RANDOM_CMDS  = 430;
    localparam int CALM_ITEMS   = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 2 * GRID_SIZE + 20;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [STEPS_W-1:0] steps;
    } plot_cmd_t;

    typedef struct {
        logic [ROW_W-1:0]   row_bits;
        logic [COORD_W-1:0] row_index;
        logic               last;
        logic               status;
    } plot_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [CMD_W-1:0]   cmd       = '0;
    logic [STEPS_W-1:0] steps     = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [ROW_W-1:0]   row_bits;
    logic [COORD_W-1:0] row_index;
    logic               last;
    logic               status;

    // Plotter image kept by the testbench
    logic [ROW_W-1:0]   canvas_img [GRID_SIZE];
    logic [COORD_W-1:0] cursor_x    = '0;
    logic [COORD_W-1:0] cursor_y    = '0;
    logic [HEAD_W-1:0]  facing      = HEAD_EAST;
    logic               pen_is_down = 1'b0;

    plot_cmd_t pending_cmds [$];
    plot_row_t expected_rows [$];

    logic req_fire    = 1'b0;
    logic timed_out   = 1'b0;
    logic hold_done   = 1'b0;
    int   cmds_total  = 0;
    int   cmds_accepted = 0;
    int   rows_checked  = 0;
    int   mismatches    = 0;
    int   moves_seen    = 0;
    int   dumps_seen    = 0;
    int   bad_cmds_seen = 0;
    int   quiet_cycles  = 0;
    int   gap_left      = 0;
    int   stall_left    = 0;
    int   hold_left     = 0;

    turtle_pen_plotter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .steps     (steps),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .row_bits  (row_bits),
        .row_index (row_index),
        .last      (last),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int r = 0; r < GRID_SIZE; r++)
        begin
            canvas_img[r] = '0;
        end
    end

    // Mark the cell under the cursor
    task automatic mark_cursor();
        canvas_img[cursor_y][cursor_x] = 1'b1;
    endtask

    // Apply one transaction to the image and queue the rows it should produce
    task automatic plot_command(input plot_cmd_t c);
        plot_row_t r;
        r.row_bits  = '0;
        r.row_index = '0;
        r.last      = 1'b1;
        r.status    = STATUS_OK;
        case (c.cmd)
            CMD_PEN_UP:
                pen_is_down = 1'b0;
            CMD_PEN_DOWN:
            begin
                pen_is_down = 1'b1;
                mark_cursor();
            end
            CMD_RIGHT:
                facing = facing + 1'b1;
            CMD_LEFT:
                facing = facing - 1'b1;
            CMD_MOVE:
            begin
                moves_seen++;
                for (int i = 0; i < int'(c.steps); i++)
                begin
                    // pin at the grid edge
                    case (facing)
                        HEAD_NORTH: if (cursor_y > 0) cursor_y = cursor_y - 1'b1;
                        HEAD_EAST:  if (cursor_x < GRID_SIZE - 1) cursor_x = cursor_x + 1'b1;
                        HEAD_SOUTH: if (cursor_y < GRID_SIZE - 1) cursor_y = cursor_y + 1'b1;
                        default:    if (cursor_x > 0) cursor_x = cursor_x - 1'b1;
                    endcase
                    if (pen_is_down)
                        mark_cursor();
                end
            end
            CMD_DUMP:
            begin
                dumps_seen++;
                for (int i = 0; i < GRID_SIZE; i++)
                begin
                    r.row_bits  = canvas_img[i];
                    r.row_index = COORD_W'(i);
                    r.last      = (i == GRID_SIZE - 1);
                    expected_rows.push_back(r);
                end
            end
            default:
            begin
                bad_cmds_seen++;
                r.status = STATUS_BAD_CMD;
            end
        endcase
        if (c.cmd != CMD_DUMP)
            expected_rows.push_back(r);
    endtask

    // Drive request transactions from the pending queue
    always @(negedge clk)
    begin : cmd_driver
        logic      nxt_valid;
        plot_cmd_t c;
        nxt_valid = req_valid;
        if (rst_n && !(req_valid && !req_fire))
        begin
            nxt_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_cmds.size() > 0)
            begin
                if (pending_cmds.size() >= CALM_ITEMS && $urandom_range(0, 99) < 15)
                    gap_left = $urandom_range(1, 9) - 1;
                else
                begin
                    c = pending_cmds.pop_front();
                    cmd   <= c.cmd;
                    steps <= c.steps;
                    nxt_valid = 1'b1;
                end
            end
        end
        req_valid <= nxt_valid;
    end

    // Pace the result side: short random stalls plus one long hold-off
    always @(negedge clk)
    begin : rsp_pacer
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (!hold_done && cmds_accepted >= 25 && expected_rows.size() >= GRID_SIZE / 2)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            nxt_stall = 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            nxt_stall = 1'b1;
        end
        else if (pending_cmds.size() >= CALM_ITEMS && $urandom_range(0, 99) < 15)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            nxt_stall = 1'b1;
        end
        rsp_stall <= nxt_stall;
    end

    // Sample both handshakes: predict on accepted commands, then check results
    always @(posedge clk)
    begin : plot_monitor
        logic      took_cmd;
        logic      took_row;
        plot_cmd_t c;
        plot_row_t exp_row;
        took_cmd = rst_n && req_valid && !req_stall;
        took_row = rst_n && rsp_valid && !rsp_stall;
        req_fire <= took_cmd;
        if (took_cmd)
        begin
            c.cmd   = cmd;
            c.steps = steps;
            plot_command(c);
            cmds_accepted++;
        end
        if (took_row)
        begin
            rows_checked++;
            if (expected_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result: row %0d bits %h last %b status %b",
                             $time, row_index, row_bits, last, status);
            end
            else
            begin
                exp_row = expected_rows.pop_front();
                if (row_bits !== exp_row.row_bits || row_index !== exp_row.row_index ||
                    last !== exp_row.last || status !== exp_row.status)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("[%0t] mismatch: expected row %0d bits %h last %b status %b,",
                               $time, exp_row.row_index, exp_row.row_bits, exp_row.last,
                               exp_row.status);
                        $display(" got row %0d bits %h last %b status %b",
                                 row_index, row_bits, last, status);
                    end
                end
            end
        end
        // Watchdog: count cycles with no transaction on either side
        if (rst_n)
        begin
            if (took_cmd || took_row)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
                timed_out <= 1'b1;
        end
    end

    initial
    begin : stimulus
        plot_cmd_t c;
        int        pick;

        // Directed part: edges in every heading, turn wrap, zero move, unknown codes
        pending_cmds.push_back('{CMD_DUMP,     8'd0});
        pending_cmds.push_back('{CMD_PEN_DOWN, 8'd0});
        pending_cmds.push_back('{CMD_MOVE,     8'd255});
        pending_cmds.push_back('{CMD_RIGHT,    8'd0});
        pending_cmds.push_back('{CMD_MOVE,     8'd255});
        pending_cmds.push_back('{CMD_RIGHT,    8'd0});
        pending_cmds.push_back('{CMD_MOVE,     8'd0});
        pending_cmds.push_back('{CMD_MOVE,     8'd255});
        pending_cmds.push_back('{CMD_RIGHT,    8'd0});
        pending_cmds.push_back('{CMD_MOVE,     8'd255});
        pending_cmds.push_back('{CMD_LEFT,     8'd255});
        pending_cmds.push_back('{CMD_MOVE,     8'd3});
        pending_cmds.push_back('{CMD_PEN_UP,   8'd0});
        pending_cmds.push_back('{CMD_LEFT,     8'd0});
        pending_cmds.push_back('{CMD_MOVE,     8'd10});
        pending_cmds.push_back('{CMD_LEFT,     8'd0});
        pending_cmds.push_back('{CMD_MOVE,     8'd10});
        pending_cmds.push_back('{CMD_UNUSED_A, 8'd255});
        pending_cmds.push_back('{CMD_UNUSED_B, 8'h55});
        pending_cmds.push_back('{CMD_PEN_DOWN, 8'hAA});
        pending_cmds.push_back('{CMD_DUMP,     8'd255});

        // Random part: mostly short moves with the pen toggling, a few dumps
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            pick    = $urandom_range(0, 99);
            c.steps = STEPS_W'($urandom_range(0, 255));
            if (pick < 45 || pick >= 90)
            begin
                c.cmd = CMD_MOVE;
                pick  = $urandom_range(0, 99);
                if (pick < 70)
                    c.steps = STEPS_W'($urandom_range(0, 7));
                else if (pick < 90)
                    c.steps = STEPS_W'($urandom_range(8, 63));
            end
            else if (pick < 55)
                c.cmd = CMD_PEN_DOWN;
            else if (pick < 63)
                c.cmd = CMD_PEN_UP;
            else if (pick < 72)
                c.cmd = CMD_RIGHT;
            else if (pick < 81)
                c.cmd = CMD_LEFT;
            else if (pick < 86)
                c.cmd = CMD_DUMP;
            else
                c.cmd = ($urandom_range(0, 1) != 0) ? CMD_UNUSED_A : CMD_UNUSED_B;
            pending_cmds.push_back(c);
        end
        cmds_total = pending_cmds.size();

        // Hold reset, then release it away from the sampling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every command taken and every result seen
        while (!timed_out && !(cmds_accepted == cmds_total && expected_rows.size() == 0))
            @(negedge clk);
        if (!timed_out)
            repeat (TAIL_CYCLES) @(negedge clk);

        $display("Ran %0d of %0d commands (%0d moves, %0d dumps, %0d unknown codes)",
                 cmds_accepted, cmds_total, moves_seen, dumps_seen, bad_cmds_seen);
        $display("Checked %0d result rows, %0d mismatches%s",
                 rows_checked, mismatches, timed_out ? ", stopped by watchdog" : "");
        if (!timed_out && mismatches == 0)
            $display("** turtle_pen_plotter_core: PASSED **");
        else
            $display("** turtle_pen_plotter_core: FAILED **");
        $finish;
    end

endmodule
